// ===== hdl/env_block_mac_address_parser_macros.svh =====
// Assertion macros shared by the parser's checker.
// No dependencies; take in with `include before use.
`ifndef ENV_BLOCK_MAC_ADDRESS_PARSER_MACROS_SVH
`define ENV_BLOCK_MAC_ADDRESS_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define EMBAP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define EMBAP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/embap_pkg.sv =====
// Types, constants and character helpers for the environment MAC parser.
// No dependencies.
package embap_pkg;

    localparam logic [3:0] HEADER_BYTES = 4'd9;
    localparam logic [2:0] KEY_LAST     = 3'd7;
    localparam logic [2:0] PAIR_LAST    = 3'd5;
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_ENTRY  = 3'd1,
        PH_MATCH  = 3'd2,
        PH_SKIP   = 3'd3,
        PH_HIGH   = 3'd4,
        PH_LOW    = 3'd5,
        PH_SEP    = 3'd6,
        PH_DONE   = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } embap_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] mac_address;
    } embap_out_t;

    typedef struct packed {
        logic       emit;
        embap_out_t data;
    } embap_res_t;

    // Characters of "ethaddr=".
    function automatic logic [7:0] key_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h65;
            3'd1:    ch = 8'h74;
            3'd2:    ch = 8'h68;
            3'd3:    ch = 8'h61;
            3'd4:    ch = 8'h64;
            3'd5:    ch = 8'h64;
            3'd6:    ch = 8'h72;
            default: ch = 8'h3D;
        endcase
        return ch;
    endfunction

    function automatic logic is_white(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    // Bit 4 flags a hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== hdl/env_block_mac_address_parser.sv =====
// Boot environment MAC address parser. Takes the environment buffer one byte per
// request on s_ (last_byte marks the final byte), skips a 9-byte header, then looks
// through the NUL-separated name=value entries for "ethaddr". An entry that begins
// with NUL ends the search. The value is decoded as six hex pairs; whitespace may
// come before either digit and colons may follow a pair. Exactly one result leaves
// on m_ per buffer: status 0 with mac_address (first byte in bits 47:40), status 1
// for a malformed value, status 2 when the name is absent. mac_address is zero
// unless status is 0. Bytes after the result are dropped up to last_byte, after
// which the next byte starts a new buffer. Throughput is one byte per clock while
// m_ready is high. A result is shown on m_ once the byte that decides it has been
// accepted into the input register, decoded, and captured in the result register.
// While a result sits unread with m_ready low, one more byte is taken into the
// input register and then s_ready drops.
// Depends on embap_pkg and the embap_ submodules.
module env_block_mac_address_parser import embap_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  embap_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output embap_out_t m_data
);

    logic       out_space;
    logic       fire;
    embap_in_t  item;
    embap_res_t res;

    // Input register: hold a request until the result side has room.
    embap_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .out_space (out_space),
        .fire      (fire),
        .item      (item)
    );

    // Advance the scan state by one byte whenever the held request moves on.
    embap_scanner u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .res     (res)
    );

    // Result register: hold the result until the consumer takes it.
    embap_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .res       (res),
        .out_space (out_space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== hdl/embap_in_stage.sv =====
// Input register for the parser: holds one request and raises ready when it drains.
// Depends on embap_pkg.
module embap_in_stage import embap_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  embap_in_t s_data,
    input  logic      out_space,
    output logic      fire,
    output embap_in_t item
);

    logic      valid_reg;
    logic      valid_next;
    embap_in_t item_reg;

    assign fire       = valid_reg && out_space;
    assign s_ready    = !valid_reg || fire;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !fire);
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

endmodule

// ===== hdl/embap_scanner.sv =====
// Scan state and per-byte decode: header skip, key match, hex pair decode.
// Depends on embap_pkg.
module embap_scanner import embap_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  embap_in_t  item,
    output embap_res_t res
);

    phase_t      phase_reg,  phase_next;
    logic [3:0]  hc_reg,     hc_next;
    logic [2:0]  mp_reg,     mp_next;
    logic [2:0]  dc_reg,     dc_next;
    logic [3:0]  hn_reg,     hn_next;
    logic [47:0] mac_reg,    mac_next;
    logic        given_reg,  given_next;

    always_comb begin
        phase_t     ph;
        logic [7:0] c;
        logic [4:0] hx;
        logic [2:0] key_pos;
        ph = phase_reg;
        c  = item.data_byte;
        hx = hex_digit(c);
        key_pos = 3'd0;
        if (ph == PH_HEADER && hc_reg >= HEADER_BYTES) begin
            ph = PH_ENTRY;
        end
        phase_next = ph;
        hc_next    = hc_reg;
        mp_next    = mp_reg;
        dc_next    = dc_reg;
        hn_next    = hn_reg;
        mac_next   = mac_reg;
        given_next = given_reg;
        res        = '0;
        res.data.status = ST_NONE;

        case (ph)
            PH_HEADER: begin
                hc_next = hc_reg + 4'd1;
            end
            PH_ENTRY, PH_MATCH: begin
                key_pos = (ph == PH_ENTRY) ? 3'd0 : mp_reg;
                if (ph == PH_ENTRY && c == CHAR_NUL) begin
                    res.emit        = 1'b1;
                    res.data.status = ST_NONE;
                    given_next      = 1'b1;
                    phase_next      = PH_DONE;
                end else if (c == key_char(key_pos)) begin
                    if (key_pos == KEY_LAST) begin
                        mp_next    = key_pos;
                        phase_next = PH_HIGH;
                        dc_next    = 3'd0;
                        mac_next   = '0;
                    end else begin
                        mp_next    = key_pos + 3'd1;
                        phase_next = PH_MATCH;
                    end
                end else begin
                    mp_next    = key_pos;
                    phase_next = (c == CHAR_NUL) ? PH_ENTRY : PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (c == CHAR_NUL) begin
                    phase_next = PH_ENTRY;
                end
            end
            PH_SEP, PH_HIGH: begin
                if (ph == PH_SEP && c == CHAR_COLON) begin
                    phase_next = PH_SEP;
                end else if (is_white(c)) begin
                    phase_next = PH_HIGH;
                end else if (!hx[4]) begin
                    res.emit        = 1'b1;
                    res.data.status = ST_BAD;
                    given_next      = 1'b1;
                    phase_next      = PH_DONE;
                end else begin
                    hn_next    = hx[3:0];
                    phase_next = PH_LOW;
                end
            end
            PH_LOW: begin
                if (is_white(c)) begin
                    phase_next = PH_LOW;
                end else if (!hx[4]) begin
                    res.emit        = 1'b1;
                    res.data.status = ST_BAD;
                    given_next      = 1'b1;
                    phase_next      = PH_DONE;
                end else begin
                    mac_next = {mac_reg[39:0], hn_reg, hx[3:0]};
                    dc_next  = dc_reg + 3'd1;
                    if (dc_reg >= PAIR_LAST) begin
                        res.emit             = 1'b1;
                        res.data.status      = ST_OK;
                        res.data.mac_address = {mac_reg[39:0], hn_reg, hx[3:0]};
                        given_next           = 1'b1;
                        phase_next           = PH_DONE;
                    end else begin
                        phase_next = PH_SEP;
                    end
                end
            end
            default: begin
                phase_next = ph;
            end
        endcase

        // Buffer end: report if nothing was reported yet, then start over.
        if (item.last_byte) begin
            if (!res.emit && !given_reg) begin
                res.emit        = 1'b1;
                res.data.status = (phase_next inside {PH_HIGH, PH_LOW, PH_SEP}) ?
                                  ST_BAD : ST_NONE;
                res.data.mac_address = '0;
            end
            phase_next = PH_HEADER;
            hc_next    = 4'd0;
            mp_next    = 3'd0;
            dc_next    = 3'd0;
            hn_next    = 4'd0;
            mac_next   = '0;
            given_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            hc_reg    <= 4'd0;
            mp_reg    <= 3'd0;
            dc_reg    <= 3'd0;
            given_reg <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            mp_reg    <= mp_next;
            dc_reg    <= dc_next;
            given_reg <= given_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hn_reg  <= 4'd0;
            mac_reg <= '0;
        end else if (fire) begin
            hn_reg  <= hn_next;
            mac_reg <= mac_next;
        end
    end

endmodule

// ===== hdl/embap_out_stage.sv =====
// Result register: captures a finished result and holds it until taken.
// Depends on embap_pkg.
module embap_out_stage import embap_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  embap_res_t res,
    output logic       out_space,
    output logic       m_valid,
    input  logic       m_ready,
    output embap_out_t m_data
);

    logic       valid_reg;
    logic       valid_next;
    embap_out_t data_reg;

    assign out_space  = !valid_reg || m_ready;
    assign valid_next = (fire && res.emit) || (valid_reg && !m_ready);
    assign m_valid    = valid_reg;
    assign m_data     = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res.emit) begin
            data_reg <= res.data;
        end
    end

endmodule

// ===== hdl/embap_checker.sv =====
// Port-level checks for the parser, bound to the top level.
// Depends on embap_pkg and env_block_mac_address_parser_macros.svh.
`include "env_block_mac_address_parser_macros.svh"

module embap_checker import embap_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input embap_in_t  s_data,
    input logic       m_valid,
    input logic       m_ready,
    input embap_out_t m_data
);

    `EMBAP_ASSERT_IMP(a_mac_zero, aclk, aresetn, m_valid && m_data.status != ST_OK, m_data.mac_address == 48'd0, "mac_address not zero on failed result")

    `EMBAP_ASSERT_IMP(a_status_code, aclk, aresetn, m_valid, m_data.status == ST_OK || m_data.status == ST_BAD || m_data.status == ST_NONE, "undefined status code")

    `EMBAP_ASSERT_NXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")

    `EMBAP_ASSERT_NXT(a_request_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_data), "stalled request changed")

    `EMBAP_ASSERT_NXT(a_no_result_idle, aclk, aresetn, !m_valid && !s_valid && !$past(s_valid), !m_valid, "result without a pending request")

endmodule

bind env_block_mac_address_parser embap_checker u_embap_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for env_block_mac_address_parser: a short directed table, then
// random environment buffers, each result checked against the table or a behavioral model.
// Depends on embap_pkg and the parser RTL.
module testbench;
    import embap_pkg::*;

    // Name being searched for, first character in the top byte.
    localparam logic [63:0] KEY_TEXT    = "ethaddr=";
    localparam int          ITEM_GOAL   = 1650;
    localparam int          BUFFER_GOAL = 40;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    embap_in_t  s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    embap_out_t m_data;

    env_block_mac_address_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    // Parser model state.
    phase_t      scan_ph;
    logic [3:0]  hdr_cnt;
    logic [2:0]  key_pos;
    logic [2:0]  pair_cnt;
    logic [3:0]  hi_nib;
    logic [47:0] mac_acc;
    logic        res_done;

    // Results the parser still owes, oldest first.
    embap_out_t  mac_expect_q[$];

    // Bytes of the buffer being sent.
    logic [7:0]  env_bytes[$];

    typedef struct {
        embap_in_t  req;
        bit         emits;
        embap_out_t res;
    } dir_row_t;
    dir_row_t    dir_rows[$];

    int  err_count    = 0;
    int  sent_items   = 0;
    int  live_items   = 0;
    int  buffers_sent = 0;
    int  status_seen[3];
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;
    int  stall_left   = 0;

    function automatic logic [7:0] key_at(input int i);
        return KEY_TEXT[63 - 8 * i -: 8];
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic int hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
        if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
        return -1;
    endfunction

    task automatic clear_parser();
        scan_ph  = PH_HEADER;
        hdr_cnt  = '0;
        key_pos  = '0;
        pair_cnt = '0;
        hi_nib   = '0;
        mac_acc  = '0;
        res_done = 1'b0;
    endtask

    // Emit this buffer's one result and ignore everything up to the last byte.
    task automatic close_buffer(input logic [1:0] st, input logic [47:0] mac,
                                output bit emitted, output embap_out_t res);
        emitted         = 1'b1;
        res.status      = st;
        res.mac_address = (st == ST_OK) ? mac : 48'd0;
        res_done        = 1'b1;
        scan_ph         = PH_DONE;
    endtask

    // Advance the model by one byte; report the result it causes, if any.
    task automatic parse_byte(input embap_in_t req, output bit emitted,
                              output embap_out_t res);
        logic [7:0] c;
        int         d;
        c       = req.data_byte;
        emitted = 1'b0;
        res     = '0;
        if (scan_ph == PH_HEADER && hdr_cnt >= HEADER_BYTES) scan_ph = PH_ENTRY;
        case (scan_ph)
            PH_HEADER: hdr_cnt = hdr_cnt + 4'd1;
            PH_ENTRY, PH_MATCH: begin
                if (scan_ph == PH_ENTRY && c == CHAR_NUL) begin
                    // an empty entry ends the list
                    close_buffer(ST_NONE, 48'd0, emitted, res);
                end else begin
                    if (scan_ph == PH_ENTRY) key_pos = 3'd0;
                    if (c == key_at(int'(key_pos))) begin
                        if (key_pos == 3'd7) begin
                            scan_ph  = PH_HIGH;
                            pair_cnt = '0;
                            mac_acc  = '0;
                        end else begin
                            key_pos = key_pos + 3'd1;
                            scan_ph = PH_MATCH;
                        end
                    end else begin
                        scan_ph = (c == CHAR_NUL) ? PH_ENTRY : PH_SKIP;
                    end
                end
            end
            PH_SKIP: if (c == CHAR_NUL) scan_ph = PH_ENTRY;
            PH_SEP, PH_HIGH: begin
                // colons only count as separators after a whole pair
                if (!(scan_ph == PH_SEP && c == CHAR_COLON)) begin
                    d = hex_val(c);
                    if (is_space(c)) begin
                        scan_ph = PH_HIGH;
                    end else if (d < 0) begin
                        close_buffer(ST_BAD, 48'd0, emitted, res);
                    end else begin
                        hi_nib  = d[3:0];
                        scan_ph = PH_LOW;
                    end
                end
            end
            PH_LOW: begin
                d = hex_val(c);
                if (!is_space(c)) begin
                    if (d < 0) begin
                        close_buffer(ST_BAD, 48'd0, emitted, res);
                    end else begin
                        mac_acc  = {mac_acc[39:0], hi_nib, d[3:0]};
                        pair_cnt = pair_cnt + 3'd1;
                        // sixth pair done: report at once, trailing text is never seen
                        if (pair_cnt >= 3'd6) close_buffer(ST_OK, mac_acc, emitted, res);
                        else scan_ph = PH_SEP;
                    end
                end
            end
            default: ;
        endcase
        if (req.last_byte) begin
            // buffer end: mid-value is malformed, anywhere else the name was absent
            if (!emitted && !res_done) begin
                if (scan_ph inside {PH_HIGH, PH_LOW, PH_SEP})
                    close_buffer(ST_BAD, 48'd0, emitted, res);
                else
                    close_buffer(ST_NONE, 48'd0, emitted, res);
            end
            clear_parser();
        end
    endtask

    // Present one request, hold it until accepted, then log what it should cause.
    // A typed row overrides the model with the result written into the table.
    task automatic send_request(input embap_in_t req, input bit typed,
                                input bit typed_emit, input embap_out_t typed_res);
        bit         emitted;
        bit         counted;
        embap_out_t res;
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = req;
        do @(posedge aclk); while (!s_ready);
        counted = (scan_ph != PH_DONE);
        parse_byte(req, emitted, res);
        if (typed) begin
            emitted = typed_emit;
            res     = typed_res;
        end
        if (emitted) mac_expect_q.push_back(res);
        if (counted) live_items++;
        sent_items++;
    endtask

    // Drop valid for the requested gap, if any, and scramble the idle payload.
    task automatic pause_sender(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid          = 1'b0;
            s_data.data_byte = 8'($urandom_range(0, 255));
            s_data.last_byte = 1'($urandom_range(0, 1));
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // Hold off the sender until every owed result has come out.
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (mac_expect_q.size() != 0) @(posedge aclk);
    endtask

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (tx_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + v;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    function automatic logic [7:0] space_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'h09 + 8'(r);
    endfunction

    // Non-NUL text, mostly printable.
    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 9) < 8) return 8'($urandom_range(8'h20, 8'h7E));
        return 8'($urandom_range(8'h80, 8'hFF));
    endfunction

    // Non-hex, non-space characters; all but the colon break a value wherever they land.
    function automatic logic [7:0] junk_char();
        case ($urandom_range(0, 6))
            0:       return CHAR_NUL;
            1:       return 8'h67;
            2:       return 8'h47;
            3:       return CHAR_COLON;
            4:       return 8'h3D;
            5:       return 8'hFF;
            default: return 8'($urandom_range(8'h67, 8'h7E));
        endcase
    endfunction

    // Mostly non-matching entry: a random-length prefix of the name, then other text.
    task automatic add_other_entry();
        int k;
        k = $urandom_range(0, 7);
        for (int i = 0; i < k; i++) env_bytes.push_back(key_at(i));
        repeat ($urandom_range(1, 5)) env_bytes.push_back(text_char());
        env_bytes.push_back(CHAR_NUL);
    endtask

    // The ethaddr entry: six pairs with random spacing, colons and digit case.
    // A quarter of them carry one junk character somewhere in the value.
    task automatic add_mac_entry();
        logic [7:0] val[$];
        int         r;
        for (int i = 0; i < 8; i++) env_bytes.push_back(key_at(i));
        for (int p = 0; p < 6; p++) begin
            for (int j = 0; j < 2; j++) begin
                r = $urandom_range(0, 9);
                repeat ((r < 6) ? 0 : (r < 9) ? 1 : 3) val.push_back(space_char());
                val.push_back(hex_char(4'($urandom_range(0, 15))));
            end
            if (p < 5) begin
                r = $urandom_range(0, 9);
                repeat ((r < 2) ? 0 : (r < 9) ? 1 : 2) val.push_back(CHAR_COLON);
            end
        end
        if ($urandom_range(0, 3) == 0) val[$urandom_range(0, val.size() - 1)] = junk_char();
        foreach (val[i]) env_bytes.push_back(val[i]);
        repeat ($urandom_range(0, 4)) env_bytes.push_back(text_char());
    endtask

    // One random buffer: mostly header plus entries, some pure noise, some cut short.
    task automatic build_buffer();
        int cut;
        env_bytes.delete();
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 40))
                env_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00
                                                                : 8'($urandom_range(0, 255)));
        end else begin
            repeat (HEADER_BYTES) env_bytes.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 2)) add_other_entry();
            if ($urandom_range(0, 9) < 8) add_mac_entry();
            if ($urandom_range(0, 9) < 7) env_bytes.push_back(CHAR_NUL);
            repeat ($urandom_range(0, 3)) env_bytes.push_back(text_char());
        end
        if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, env_bytes.size());
            while (env_bytes.size() > cut) void'(env_bytes.pop_back());
        end
    endtask

    function automatic void add_row(input logic [7:0] b, input bit last, input bit emits,
                                    input logic [1:0] st);
        dir_row_t row;
        row.req.data_byte   = b;
        row.req.last_byte   = last;
        row.emits           = emits;
        row.res.status      = st;
        row.res.mac_address = 48'd0;
        dir_rows.push_back(row);
    endfunction

    // Result receiver: stall at random, with calm stretches that start no new stalls.
    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
        if (stall_left != 0) begin
            m_ready    = 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready = 1'b1;
            if (!rx_calm && $urandom_range(0, 9) < 3)
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                          : $urandom_range(1, 3);
        end
    end

    // Compare each accepted result with the oldest one owed.
    always @(posedge aclk) begin : result_check
        embap_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (mac_expect_q.size() == 0) begin
                $display("%0t: unexpected result: status %0d mac %012h", $time,
                         m_data.status, m_data.mac_address);
                err_count++;
            end else begin
                want = mac_expect_q.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d", $time,
                             want.status, m_data.status);
                    err_count++;
                end
                if (m_data.mac_address !== want.mac_address) begin
                    $display("%0t: mac_address mismatch: expected %012h, got %012h", $time,
                             want.mac_address, m_data.mac_address);
                    err_count++;
                end
                if (m_data.status <= ST_NONE) status_seen[m_data.status]++;
            end
        end
    end

    initial begin
        embap_in_t req;

        foreach (status_seen[i]) status_seen[i] = 0;
        clear_parser();

        // Last flag on the very first byte: the buffer ends inside the header.
        add_row(8'hFF, 1'b1, 1'b1, ST_NONE);
        // Extreme header bytes, then the whole name with '=' as the final byte:
        // the value is empty, so the result is malformed.
        for (int i = 0; i < 9; i++) add_row(i[0] ? 8'hFF : 8'h00, 1'b0, 1'b0, ST_OK);
        for (int i = 0; i < 7; i++) add_row(key_at(i), 1'b0, 1'b0, ST_OK);
        add_row(key_at(7), 1'b1, 1'b1, ST_BAD);
        // Empty first entry ends the search at once; the next byte is ignored
        // even though it carries the last flag.
        for (int i = 0; i < 9; i++) add_row(i[0] ? 8'h00 : 8'hFF, 1'b0, 1'b0, ST_OK);
        add_row(CHAR_NUL, 1'b0, 1'b1, ST_NONE);
        add_row(8'h78, 1'b1, 1'b0, ST_OK);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].req, 1'b1, dir_rows[i].emits, dir_rows[i].res);
            pause_sender(pick_gap());
        end
        wait_for_results();

        // Random buffers until enough bytes were parsed and enough buffers were sent.
        while (live_items < ITEM_GOAL || buffers_sent < BUFFER_GOAL) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            build_buffer();
            foreach (env_bytes[i]) begin
                req.data_byte = env_bytes[i];
                req.last_byte = (i == env_bytes.size() - 1);
                send_request(req, 1'b0, 1'b0, '0);
                pause_sender(pick_gap());
            end
            buffers_sent++;
            if (buffers_sent == 15) wait_for_results();
        end

        // Drain, then give a stray late result time to show up.
        wait_for_results();
        repeat (12) @(posedge aclk);

        $display("Sent %0d buffers, %0d bytes (%0d before a result was decided).",
                 buffers_sent + 3, sent_items, live_items);
        $display("Results: %0d MAC decoded, %0d malformed, %0d not found.",
                 status_seen[ST_OK], status_seen[ST_BAD], status_seen[ST_NONE]);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Guard against a hang: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, mac_expect_q.size());
        $display("FAIL");
        $finish;
    end

endmodule
